// ----- rtl/binary_to_decimal_ascii_core_macros.svh -----
// Assertion macros for the binary-to-decimal ASCII core.
// Standalone header; included by files that carry concurrent checks.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define B2DA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/b2da_pkg.sv -----
// Package for the binary-to-decimal ASCII core: widths, micro-op codes,
// control word and status types, and the microprogram ROM. No dependencies.
package b2da_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_DIGITS = 10;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 5;
   localparam int CHAR_W     = 6;
   localparam int STEP_W     = 2;

   localparam logic [IDX_W-1:0]  TOP_IDX    = IDX_W'(NUM_DIGITS - 1);
   localparam logic [CNT_W-1:0]  LAST_SHIFT = CNT_W'(VALUE_W - 1);
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_DABBLE = 2'd1,
      OP_SKIP   = 2'd2,
      OP_EMIT   = 2'd3
   } op_type;

   // Jump is taken when the named condition holds; otherwise step + 1.
   typedef enum logic [2:0] {
      JMP_NEVER       = 3'd0,
      JMP_NO_REQ      = 3'd1,
      JMP_SHIFT_LEFT  = 3'd2,
      JMP_LEAD_ZERO   = 3'd3,
      JMP_NOT_LAST_TX = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_accept;  // input request taken this cycle
      logic shift_more;  // more shift-add-3 passes remain
      logic lead_zero;   // current top digit is a leading zero
      logic last_tx;     // final digit taken this cycle
   } status_type;

   localparam step_type STEP_LOAD   = 2'd0;
   localparam step_type STEP_DABBLE = 2'd1;
   localparam step_type STEP_SKIP   = 2'd2;
   localparam step_type STEP_EMIT   = 2'd3;

   function automatic ctrl_word_type b2da_rom(input step_type step);
      ctrl_word_type cw;
      case (step)
         STEP_LOAD:   cw = '{op: OP_LOAD,   cond: JMP_NO_REQ,      target: STEP_LOAD};
         STEP_DABBLE: cw = '{op: OP_DABBLE, cond: JMP_SHIFT_LEFT,  target: STEP_DABBLE};
         STEP_SKIP:   cw = '{op: OP_SKIP,   cond: JMP_LEAD_ZERO,   target: STEP_SKIP};
         STEP_EMIT:   cw = '{op: OP_EMIT,   cond: JMP_NOT_LAST_TX, target: STEP_EMIT};
         default:     cw = '{op: OP_LOAD,   cond: JMP_NEVER,       target: STEP_LOAD};
      endcase
      return cw;
   endfunction

endpackage

// ----- rtl/b2da_seq.sv -----
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on b2da_pkg.
module b2da_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  b2da_pkg::status_type   status,
   output b2da_pkg::op_type       op
);
   import b2da_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw;
   logic          take;

   always_comb begin
      cw = b2da_rom(step_ff);
      case (cw.cond)
         JMP_NEVER:       take = 1'b0;
         JMP_NO_REQ:      take = !status.req_accept;
         JMP_SHIFT_LEFT:  take = status.shift_more;
         JMP_LEAD_ZERO:   take = status.lead_zero;
         JMP_NOT_LAST_TX: take = !status.last_tx;
         default:         take = 1'b0;
      endcase
      step_in = take ? cw.target : step_ff + 1'b1;  // emit step wraps to load
      op      = cw.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- rtl/b2da_dp.sv -----
// Datapath: binary shift register, ten BCD digit registers with add-3
// correction, shift counter and digit pointer. Depends on b2da_pkg.
module b2da_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  b2da_pkg::op_type                 op,
   input  logic                             req_tvalid,
   input  logic [b2da_pkg::VALUE_W-1:0]     value,
   input  logic                             rsp_tready,
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
   output logic                             last,
   output b2da_pkg::status_type             status
);
   import b2da_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [3:0]         dig_ff [NUM_DIGITS];
   logic [3:0]         dig_in [NUM_DIGITS];
   logic [3:0]         adj    [NUM_DIGITS];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [3:0]         cur;
   logic               req_acc, rsp_acc;

   assign req_tready = (op == OP_LOAD);
   assign rsp_tvalid = (op == OP_EMIT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign cur        = dig_ff[idx_ff];
   assign digit_char = ASCII_ZERO + {2'b00, cur};
   assign last       = (idx_ff == '0);

   assign status.req_accept = req_acc;
   assign status.shift_more = (cnt_ff != LAST_SHIFT);
   assign status.lead_zero  = (cur == 4'd0) && (idx_ff != '0);
   assign status.last_tx    = rsp_acc && last;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];
      end
      bin_in = bin_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig_in[i] = dig_ff[i];
      end
      case (op)
         OP_LOAD: begin
            if (req_acc) begin
               bin_in = value;
               cnt_in = '0;
               idx_in = TOP_IDX;
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  dig_in[i] = 4'd0;
               end
            end
         end
         OP_DABBLE: begin
            dig_in[0] = {adj[0][2:0], bin_ff[VALUE_W-1]};
            for (int i = 1; i < NUM_DIGITS; i++) begin
               dig_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_SKIP: begin
            if (status.lead_zero) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         OP_EMIT: begin
            if (rsp_acc && !last) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            bin_in = bin_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig_ff[i] <= dig_in[i];
      end
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// Binary-to-decimal ASCII converter top level: microcode sequencer plus datapath.
// Depends on b2da_pkg, b2da_seq, b2da_dp and binary_to_decimal_ascii_core_macros.svh.
//
// Each request on the req_ side carries one 32-bit unsigned number. The core
// answers with its decimal digits as ASCII characters on the rsp_ side, most
// significant first, without leading zeros; rsp_tlast marks the final digit,
// and zero gives the single character '0'. One request is handled at a time:
// req_tready is high only while the core waits for work. A request runs a
// load step, then 32 shift-add-3 passes through the ten BCD digit
// registers (one input bit per cycle), then a scan past leading zeros and
// finally the emission of the digits. Control is a four-step microprogram in
// a ROM (load, shift-add-3, skip zeros, emit) with a 2-bit step counter and
// conditional jumps; no state survives between requests.
`include "binary_to_decimal_ascii_core_macros.svh"

module binary_to_decimal_ascii_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic        rsp_tlast    // last digit of the number
);
   import b2da_pkg::*;

   op_type             op;
   status_type         status;
   logic [CHAR_W-1:0]  digit_char;
   logic               last;

   // Sequencer steps through the ROM program on datapath status.
   b2da_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   // Datapath executes the current micro-op and owns both handshakes.
   b2da_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_tvalid (req_tvalid),
      .value      (req_tdata),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .digit_char (digit_char),
      .last       (last),
      .status     (status)
   );

   assign rsp_tdata = {2'b00, digit_char};
   assign rsp_tlast = last;

   // Never take a request while digits are still going out.
   `B2DA_ASSERT_IMPL(a_one_at_a_time, clock, reset, rsp_tvalid, !req_tready, "request taken during output")
   // After a non-final digit leaves, the next digit follows at once.
   `B2DA_ASSERT_NEXT(a_digits_continue, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "digit stream broken")
   // Every character is an ASCII decimal digit.
   `B2DA_ASSERT_IMPL(a_digit_range, clock, reset, rsp_tvalid, (rsp_tdata[7:4] == 4'h3) && (rsp_tdata[3:0] <= 4'd9), "character is not a digit")
   // A fresh request first runs the conversion, never output straight away.
   `B2DA_ASSERT_NEXT(a_convert_first, clock, reset, req_tvalid && req_tready, !rsp_tvalid && !req_tready, "output without conversion")

endmodule
